[rtl/core/radar_target_proximity_alarm_unit_defines.svh]
// ----------------------------------------------------------------------------
// Proximity alarm assertion macros
// Concurrent check wrappers; the bodies are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RADAR_TARGET_PROXIMITY_ALARM_UNIT_DEFINES_SVH
`define RADAR_TARGET_PROXIMITY_ALARM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check held off while rst is high
`define RTPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check that also holds through reset
`define RTPA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RTPA_ASSERT(label, clk, rst, prop, msg)
`define RTPA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[rtl/core/rtpa_pkg.sv]
// ----------------------------------------------------------------------------
// Proximity alarm package
// Beat types, request and result codes, thresholds and register map.
// ----------------------------------------------------------------------------
package rtpa_pkg;

   // request types
   localparam logic [1:0] REQ_FRAME   = 2'd0;
   localparam logic [1:0] REQ_TIMEOUT = 2'd1;
   localparam logic [1:0] REQ_TICK    = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_SHOWN   = 2'd0;
   localparam logic [1:0] KIND_CLEARED = 2'd1;
   localparam logic [1:0] KIND_NONE    = 2'd2;

   // zones
   localparam logic [1:0] ZONE_SAFE    = 2'd0;
   localparam logic [1:0] ZONE_WARNING = 2'd1;
   localparam logic [1:0] ZONE_DANGER  = 2'd2;
   localparam logic [1:0] ZONE_ALARM   = 2'd3;

   // grid widths in metres
   localparam logic [3:0] GRID_10 = 4'd10;
   localparam logic [3:0] GRID_8  = 4'd8;
   localparam logic [3:0] GRID_6  = 4'd6;
   localparam logic [3:0] GRID_4  = 4'd4;

   // beep interval codes
   localparam logic [1:0] BEEP_SOLID = 2'd0;
   localparam logic [1:0] BEEP_80    = 2'd1;
   localparam logic [1:0] BEEP_200   = 2'd2;
   localparam logic [1:0] BEEP_400   = 2'd3;

   localparam logic [9:0] INTERVAL_80  = 10'd80;
   localparam logic [9:0] INTERVAL_200 = 10'd200;
   localparam logic [9:0] INTERVAL_400 = 10'd400;
   localparam logic [9:0] BEEP_ON_MS   = 10'd60;
   localparam logic [9:0] CNT_MAX      = 10'd1023;

   // detection frame identifier window
   localparam logic [10:0] ID_LO = 11'h310;
   localparam logic [10:0] ID_HI = 11'h38F;

   // auto zoom range bands, quarter metres
   localparam logic [7:0] BAND_SAFE_Q   = 8'd20;
   localparam logic [7:0] BAND_WARN_Q   = 8'd12;
   localparam logic [7:0] BAND_DANGER_Q = 8'd6;
   localparam logic [7:0] SOLID_Q       = 8'd3;

   localparam int BOX_PX = 30;

   // register map, index = paddr / 4
   localparam int         CSR_ADDR_W   = 5;
   localparam logic [2:0] REG_WARNING  = 3'd0;
   localparam logic [2:0] REG_DANGER   = 3'd1;
   localparam logic [2:0] REG_VEH_W    = 3'd2;
   localparam logic [2:0] REG_MARGIN   = 3'd3;
   localparam logic [2:0] REG_AUTOZOOM = 3'd4;
   localparam logic [2:0] REG_AUDIO    = 3'd5;

   localparam logic [7:0] WARNING_RST  = 8'd50;
   localparam logic [7:0] DANGER_RST   = 8'd20;
   localparam logic [7:0] VEH_W_RST    = 8'd20;
   localparam logic [7:0] MARGIN_RST   = 8'd5;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [10:0] can_id;
      logic [7:0]  range_byte;
      logic [7:0]  angle_byte;
      logic [7:0]  forward_byte;
      logic [7:0]  lateral_byte;
      logic [7:0]  flag_byte;
   } rtpa_req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [1:0]        zone;
      logic [3:0]        grid_m;
      logic [7:0]        target_x;
      logic [8:0]        target_y;
      logic [7:0]        vehicle_x;
      logic [8:0]        vehicle_width;
      logic              buzzer_level;
      logic [7:0]        range_q;
      logic signed [7:0] angle_deg;
      logic [7:0]        forward_q;
      logic signed [7:0] lateral_q;
   } rtpa_rsp_type;

endpackage

[rtl/core/rtpa_req_if.sv]
// ----------------------------------------------------------------------------
// Proximity alarm request channel
// Valid/ready channel carrying one radar frame, timeout or tick per beat.
// ----------------------------------------------------------------------------
interface rtpa_req_if;
   logic                  valid;
   logic                  ready;
   rtpa_pkg::rtpa_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/rtpa_rsp_if.sv]
// ----------------------------------------------------------------------------
// Proximity alarm result channel
// Valid/ready channel carrying one display and buzzer update per beat.
// ----------------------------------------------------------------------------
interface rtpa_rsp_if;
   logic                  valid;
   logic                  ready;
   rtpa_pkg::rtpa_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/radar_target_proximity_alarm_unit.sv]
// ----------------------------------------------------------------------------
// Radar target proximity alarm unit
// Decodes radar detections into display zone, grid and pixel placement, and
// runs the buzzer beep timer from millisecond ticks.
// ----------------------------------------------------------------------------
//
//  channel    dir   handshake         beat
//  ---------  ----  ----------------  ------------------------------------
//  req_chan   in    valid/ready       frame, receive timeout or 1 ms tick
//  rsp_chan   out   valid/ready       one result per request beat
//  csr_*      in    APB, pready = 1   six config registers at 4*index
//
//  One request beat per clock sustained while rsp_chan takes results; a
//  request goes through the input register, then a single pass into the
//  result register, whose output is rsp_chan.
//  The input register keeps taking beats while a result waits, so the
//  block only stalls the request side when both registers are full.
//  Reset is synchronous and active high; config returns to defaults,
//  the target is cleared and the buzzer disarmed.
//
`include "radar_target_proximity_alarm_unit_defines.svh"

module radar_target_proximity_alarm_unit #(
   parameter int SCREEN_W = 272,
   parameter int SCREEN_H = 480
) (
   input  logic                              clock,
   input  logic                              reset,
   rtpa_req_if.sink                          req_chan,
   rtpa_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rtpa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   // ---------------------------------------------------------------------
   // Arithmetic sizing. All pixel numerators are kept unsigned and share
   // one width; the worst case is the larger of the three mappings.
   // ---------------------------------------------------------------------
   localparam int NX_MAX  = SCREEN_W * 255 + 20 * (SCREEN_W + 1);
   localparam int NY_MAX  = 40 * SCREEN_H + 20;
   localparam int NV_MAX  = SCREEN_W * 255 + 50;
   localparam int NXV_MAX = (NX_MAX > NV_MAX) ? NX_MAX : NV_MAX;
   localparam int NUM_MAX = (NXV_MAX > NY_MAX) ? NXV_MAX : NY_MAX;
   localparam int NUM_W   = $clog2(NUM_MAX + 1);
   // every divide by an odd constant sees a numerator shifted right by 2+
   localparam int DIV_W   = NUM_W - 2;
   localparam int PROD_W  = 2 * DIV_W + 1;

   // reciprocals: ceil(2^s / d) with s = DIV_W + ceil(log2 d), exact below 2^DIV_W
   localparam int SH3  = DIV_W + 2;
   localparam int SH5  = DIV_W + 3;
   localparam int SH15 = DIV_W + 4;
   localparam int SH25 = DIV_W + 5;
   localparam logic [DIV_W:0] RCP3  = (DIV_W + 1)'((longint'(1) << SH3) / 3 + 1);
   localparam logic [DIV_W:0] RCP5  = (DIV_W + 1)'((longint'(1) << SH5) / 5 + 1);
   localparam logic [DIV_W:0] RCP15 = (DIV_W + 1)'((longint'(1) << SH15) / 15 + 1);
   localparam logic [DIV_W:0] RCP25 = (DIV_W + 1)'((longint'(1) << SH25) / 25 + 1);

   // x numerator: W*lat + 2g(W+1), lat = lateral_byte - 128
   localparam logic [NUM_W-1:0] X_OFF10 = NUM_W'(20 * (SCREEN_W + 1));
   localparam logic [NUM_W-1:0] X_OFF8  = NUM_W'(16 * (SCREEN_W + 1));
   localparam logic [NUM_W-1:0] X_OFF6  = NUM_W'(12 * (SCREEN_W + 1));
   localparam logic [NUM_W-1:0] X_OFF4  = NUM_W'(8 * (SCREEN_W + 1));
   localparam logic [NUM_W-1:0] X_NEG   = NUM_W'(128 * SCREEN_W);
   // y numerator: 4gH + 2g - W*fwd
   localparam logic [NUM_W-1:0] Y_BASE10 = NUM_W'(40 * SCREEN_H + 20);
   localparam logic [NUM_W-1:0] Y_BASE8  = NUM_W'(32 * SCREEN_H + 16);
   localparam logic [NUM_W-1:0] Y_BASE6  = NUM_W'(24 * SCREEN_H + 12);
   localparam logic [NUM_W-1:0] Y_BASE4  = NUM_W'(16 * SCREEN_H + 8);
   // vehicle numerator: W*veh + 5g
   localparam logic [NUM_W-1:0] V_OFF10 = NUM_W'(50);
   localparam logic [NUM_W-1:0] V_OFF8  = NUM_W'(40);
   localparam logic [NUM_W-1:0] V_OFF6  = NUM_W'(30);
   localparam logic [NUM_W-1:0] V_OFF4  = NUM_W'(20);

   localparam logic [NUM_W-1:0] SCR_W   = NUM_W'(SCREEN_W);
   localparam logic [NUM_W-1:0] SCR_W1  = NUM_W'(SCREEN_W + 1);
   localparam logic [NUM_W-1:0] TX_MAX  = NUM_W'(SCREEN_W - rtpa_pkg::BOX_PX);
   localparam logic [NUM_W-1:0] TY_MAX  = NUM_W'(SCREEN_H - rtpa_pkg::BOX_PX);
   localparam logic [NUM_W-1:0] VW_MIN  = NUM_W'(2);

   function automatic logic [NUM_W-1:0] rcp_div(input logic [DIV_W-1:0] num,
                                                input logic [DIV_W:0]   rcp,
                                                input int               shift);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(num) * PROD_W'(rcp);
      return NUM_W'(prod >> shift);
   endfunction

   // ---------------------------------------------------------------------
   // Config registers
   // ---------------------------------------------------------------------
   logic [7:0] warning_dm_ff;
   logic [7:0] danger_dm_ff;
   logic [7:0] vehicle_width_dm_ff;
   logic [7:0] side_margin_dm_ff;
   logic       auto_zoom_ff;
   logic       audio_alarm_ff;

   logic       csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[rtpa_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         warning_dm_ff       <= rtpa_pkg::WARNING_RST;
         danger_dm_ff        <= rtpa_pkg::DANGER_RST;
         vehicle_width_dm_ff <= rtpa_pkg::VEH_W_RST;
         side_margin_dm_ff   <= rtpa_pkg::MARGIN_RST;
         auto_zoom_ff        <= 1'b1;
         audio_alarm_ff      <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            rtpa_pkg::REG_WARNING:  warning_dm_ff       <= csr_pwdata[7:0];
            rtpa_pkg::REG_DANGER:   danger_dm_ff        <= csr_pwdata[7:0];
            rtpa_pkg::REG_VEH_W:    vehicle_width_dm_ff <= csr_pwdata[7:0];
            rtpa_pkg::REG_MARGIN:   side_margin_dm_ff   <= csr_pwdata[7:0];
            rtpa_pkg::REG_AUTOZOOM: auto_zoom_ff        <= csr_pwdata[0];
            rtpa_pkg::REG_AUDIO:    audio_alarm_ff      <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         rtpa_pkg::REG_WARNING:  csr_prdata = 32'(warning_dm_ff);
         rtpa_pkg::REG_DANGER:   csr_prdata = 32'(danger_dm_ff);
         rtpa_pkg::REG_VEH_W:    csr_prdata = 32'(vehicle_width_dm_ff);
         rtpa_pkg::REG_MARGIN:   csr_prdata = 32'(side_margin_dm_ff);
         rtpa_pkg::REG_AUTOZOOM: csr_prdata = 32'(auto_zoom_ff);
         rtpa_pkg::REG_AUDIO:    csr_prdata = 32'(audio_alarm_ff);
         default:                csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake: input register -> single pass -> result register
   // ---------------------------------------------------------------------
   logic                   req_valid_ff;
   logic                   req_valid_in;
   rtpa_pkg::rtpa_req_type req_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rtpa_pkg::rtpa_rsp_type rsp_ff;
   rtpa_pkg::rtpa_rsp_type rsp_in;

   logic rsp_free;   // result register can load this edge
   logic fire;       // the held request is processed this edge
   logic req_take;

   assign rsp_free       = ~rsp_valid_ff | rsp_chan.ready;
   assign fire           = req_valid_ff & rsp_free;
   assign req_chan.ready = ~req_valid_ff | rsp_free;
   assign req_take       = req_chan.valid & req_chan.ready;
   assign req_valid_in   = req_take | (req_valid_ff & ~fire);
   assign rsp_valid_in   = fire | (rsp_valid_ff & ~rsp_chan.ready);

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // ---------------------------------------------------------------------
   // Alarm state
   // ---------------------------------------------------------------------
   logic       target_shown_ff, target_shown_in;
   logic       alarm_armed_ff,  alarm_armed_in;
   logic       buzzer_on_ff,    buzzer_on_in;
   logic [9:0] ms_since_toggle_ff, ms_since_toggle_in;
   logic [1:0] beep_code_ff,    beep_code_in;

   // ---------------------------------------------------------------------
   // Single pass
   // ---------------------------------------------------------------------
   logic             detect;
   logic [7:0]       range_r;
   logic [10:0]      range_x5;
   logic [10:0]      warn_x2;
   logic [10:0]      danger_x2;
   logic [1:0]       zone_det;
   logic [3:0]       grid_det;
   logic [1:0]       zone_sel;
   logic [3:0]       grid_sel;
   logic [7:0]       lat_bits;
   logic [7:0]       lat_abs;
   logic [10:0]      lat_x5;
   logic [10:0]      side_lim;
   logic             arm_now;
   logic [1:0]       beep_det;
   logic             run_buzzer;
   logic [1:0]       kind;
   logic [9:0]       interval_ms;
   logic [NUM_W-1:0] x_off, y_base, v_off;
   logic [NUM_W-1:0] x_raw, y_sub, v_num;
   logic [NUM_W-1:0] x_num, y_num;
   logic [NUM_W-1:0] x_quo, y_quo, v_quo;
   logic [NUM_W-1:0] x_clip, y_clip, v_clip, v_left;

   // detection decode, zone and grid
   always_comb begin
      range_r   = req_ff.range_byte;
      detect    = (req_ff.req_type == rtpa_pkg::REQ_FRAME)
                  && (req_ff.can_id inside {[rtpa_pkg::ID_LO:rtpa_pkg::ID_HI]})
                  && !req_ff.flag_byte[0];
      range_x5  = 11'({range_r, 2'b00}) + 11'(range_r);
      warn_x2   = 11'({warning_dm_ff, 1'b0});
      danger_x2 = 11'({danger_dm_ff, 1'b0});

      if (auto_zoom_ff) begin
         if (range_r > rtpa_pkg::BAND_SAFE_Q) begin
            zone_det = rtpa_pkg::ZONE_SAFE;
            grid_det = rtpa_pkg::GRID_10;
         end else if (range_r > rtpa_pkg::BAND_WARN_Q) begin
            zone_det = rtpa_pkg::ZONE_WARNING;
            grid_det = rtpa_pkg::GRID_8;
         end else if (range_r > rtpa_pkg::BAND_DANGER_Q) begin
            zone_det = rtpa_pkg::ZONE_DANGER;
            grid_det = rtpa_pkg::GRID_6;
         end else begin
            zone_det = rtpa_pkg::ZONE_ALARM;
            grid_det = rtpa_pkg::GRID_4;
         end
      end else begin
         grid_det = rtpa_pkg::GRID_10;
         // manual zones skip danger: inside the danger distance is alarm
         if (range_x5 > warn_x2) begin
            zone_det = rtpa_pkg::ZONE_SAFE;
         end else if (range_x5 > danger_x2) begin
            zone_det = rtpa_pkg::ZONE_WARNING;
         end else begin
            zone_det = rtpa_pkg::ZONE_ALARM;
         end
      end

      zone_sel = detect ? zone_det : rtpa_pkg::ZONE_SAFE;
      grid_sel = detect ? grid_det : rtpa_pkg::GRID_10;

      // lateral offset back to two's complement, then magnitude (128 fits)
      lat_bits = req_ff.lateral_byte ^ 8'h80;
      lat_abs  = lat_bits[7] ? (~lat_bits + 8'd1) : lat_bits;
      lat_x5   = 11'({lat_abs, 2'b00}) + 11'(lat_abs);
      side_lim = 11'(vehicle_width_dm_ff) + 11'({side_margin_dm_ff, 1'b0});
      arm_now  = audio_alarm_ff && (range_x5 < warn_x2) && (lat_x5 < side_lim);

      if (range_r <= rtpa_pkg::SOLID_Q) begin
         beep_det = rtpa_pkg::BEEP_SOLID;
      end else if (zone_det == rtpa_pkg::ZONE_ALARM) begin
         beep_det = rtpa_pkg::BEEP_80;
      end else if (zone_det == rtpa_pkg::ZONE_DANGER) begin
         beep_det = rtpa_pkg::BEEP_200;
      end else begin
         beep_det = rtpa_pkg::BEEP_400;
      end
   end

   // target, arming and beep timer
   always_comb begin
      target_shown_in    = target_shown_ff;
      alarm_armed_in     = alarm_armed_ff;
      beep_code_in       = beep_code_ff;
      ms_since_toggle_in = ms_since_toggle_ff;
      buzzer_on_in       = buzzer_on_ff;
      kind               = rtpa_pkg::KIND_NONE;
      run_buzzer         = 1'b1;

      if (detect) begin
         target_shown_in = 1'b1;
         alarm_armed_in  = arm_now;
         if (arm_now) begin
            beep_code_in = beep_det;
         end
         kind = rtpa_pkg::KIND_SHOWN;
      end else if (req_ff.req_type == rtpa_pkg::REQ_FRAME
                   || req_ff.req_type == rtpa_pkg::REQ_TIMEOUT) begin
         if (target_shown_ff) begin
            target_shown_in = 1'b0;
            alarm_armed_in  = 1'b0;
            kind            = rtpa_pkg::KIND_CLEARED;
         end
      end else if (req_ff.req_type == rtpa_pkg::REQ_TICK) begin
         if (ms_since_toggle_ff != rtpa_pkg::CNT_MAX) begin
            ms_since_toggle_in = ms_since_toggle_ff + 10'd1;
         end
      end else begin
         // unused request code: leave everything alone
         run_buzzer = 1'b0;
      end

      case (beep_code_in)
         rtpa_pkg::BEEP_80:  interval_ms = rtpa_pkg::INTERVAL_80;
         rtpa_pkg::BEEP_200: interval_ms = rtpa_pkg::INTERVAL_200;
         default:            interval_ms = rtpa_pkg::INTERVAL_400;
      endcase

      // forced changes keep the count; timed toggles restart it
      if (run_buzzer) begin
         if (!alarm_armed_in) begin
            buzzer_on_in = 1'b0;
         end else if (beep_code_in == rtpa_pkg::BEEP_SOLID) begin
            buzzer_on_in = 1'b1;
         end else if (buzzer_on_ff) begin
            if (ms_since_toggle_in >= rtpa_pkg::BEEP_ON_MS) begin
               buzzer_on_in       = 1'b0;
               ms_since_toggle_in = 10'd0;
            end
         end else if (ms_since_toggle_in >= interval_ms) begin
            buzzer_on_in       = 1'b1;
            ms_since_toggle_in = 10'd0;
         end
      end
   end

   // pixel mapping: floor(n / 4g) and floor(n / 10g), all half-up rounded
   always_comb begin
      case (grid_sel)
         rtpa_pkg::GRID_8: begin
            x_off  = X_OFF8;
            y_base = Y_BASE8;
            v_off  = V_OFF8;
         end
         rtpa_pkg::GRID_6: begin
            x_off  = X_OFF6;
            y_base = Y_BASE6;
            v_off  = V_OFF6;
         end
         rtpa_pkg::GRID_4: begin
            x_off  = X_OFF4;
            y_base = Y_BASE4;
            v_off  = V_OFF4;
         end
         default: begin
            x_off  = X_OFF10;
            y_base = Y_BASE10;
            v_off  = V_OFF10;
         end
      endcase

      x_raw = SCR_W * NUM_W'(req_ff.lateral_byte) + x_off;
      y_sub = SCR_W * NUM_W'(req_ff.forward_byte);
      v_num = SCR_W * NUM_W'(vehicle_width_dm_ff) + v_off;

      // a negative numerator would clamp to zero anyway
      x_num = (x_raw < X_NEG) ? '0 : (x_raw - X_NEG);
      y_num = (y_base < y_sub) ? '0 : (y_base - y_sub);

      case (grid_sel)
         rtpa_pkg::GRID_8: begin
            x_quo = x_num >> 5;
            y_quo = y_num >> 5;
            v_quo = rcp_div(DIV_W'(v_num >> 4), RCP5, SH5);
         end
         rtpa_pkg::GRID_6: begin
            x_quo = rcp_div(DIV_W'(x_num >> 3), RCP3, SH3);
            y_quo = rcp_div(DIV_W'(y_num >> 3), RCP3, SH3);
            v_quo = rcp_div(DIV_W'(v_num >> 2), RCP15, SH15);
         end
         rtpa_pkg::GRID_4: begin
            x_quo = x_num >> 4;
            y_quo = y_num >> 4;
            v_quo = rcp_div(DIV_W'(v_num >> 3), RCP5, SH5);
         end
         default: begin
            x_quo = rcp_div(DIV_W'(x_num >> 3), RCP5, SH5);
            y_quo = rcp_div(DIV_W'(y_num >> 3), RCP5, SH5);
            v_quo = rcp_div(DIV_W'(v_num >> 2), RCP25, SH25);
         end
      endcase

      x_clip = (x_quo > TX_MAX) ? TX_MAX : x_quo;
      y_clip = (y_quo > TY_MAX) ? TY_MAX : y_quo;
      if (v_quo < VW_MIN) begin
         v_clip = VW_MIN;
      end else if (v_quo > SCR_W) begin
         v_clip = SCR_W;
      end else begin
         v_clip = v_quo;
      end
      v_left = (SCR_W1 - v_clip) >> 1;
   end

   // result beat
   always_comb begin
      rsp_in.result_kind   = kind;
      rsp_in.zone          = zone_sel;
      rsp_in.grid_m        = grid_sel;
      rsp_in.target_x      = detect ? x_clip[7:0] : 8'd0;
      rsp_in.target_y      = detect ? y_clip[8:0] : 9'd0;
      rsp_in.vehicle_x     = v_left[7:0];
      rsp_in.vehicle_width = v_clip[8:0];
      rsp_in.buzzer_level  = buzzer_on_in;
      rsp_in.range_q       = detect ? range_r : 8'd0;
      rsp_in.angle_deg     = detect ? signed'(req_ff.angle_byte ^ 8'h80) : 8'sd0;
      rsp_in.forward_q     = detect ? req_ff.forward_byte : 8'd0;
      rsp_in.lateral_q     = detect ? signed'(lat_bits) : 8'sd0;
   end

   // ---------------------------------------------------------------------
   // Control and state registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         target_shown_ff    <= 1'b0;
         alarm_armed_ff     <= 1'b0;
         buzzer_on_ff       <= 1'b0;
         ms_since_toggle_ff <= 10'd0;
         beep_code_ff       <= rtpa_pkg::BEEP_400;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            target_shown_ff    <= target_shown_in;
            alarm_armed_ff     <= alarm_armed_in;
            buzzer_on_ff       <= buzzer_on_in;
            ms_since_toggle_ff <= ms_since_toggle_in;
            beep_code_ff       <= beep_code_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_chan.payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `RTPA_ASSERT(a_clear_drops_target, clock, reset, (fire && rsp_in.result_kind == rtpa_pkg::KIND_CLEARED) |=> (!target_shown_ff && !alarm_armed_ff), "cleared beat left target or alarm set")
   `RTPA_ASSERT(a_armed_needs_target, clock, reset, alarm_armed_ff |-> target_shown_ff, "alarm armed with no target shown")
   `RTPA_ASSERT(a_disarmed_is_silent, clock, reset, !alarm_armed_ff |-> !buzzer_on_ff, "buzzer sounding while disarmed")
   `RTPA_ASSERT(a_timer_moves_on_beat, clock, reset, !fire |=> $stable(ms_since_toggle_ff), "beep timer moved without a request beat")

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Proximity alarm unit testbench
// Sends radar frames, receive timeouts and millisecond ticks under several
// register settings, predicts every display and buzzer update in step, and
// compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SCREEN_W = 272;
   localparam int SCREEN_H = 480;

   // request type with no meaning: the block must pass over it untouched
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // watchdog: cycles with no beat on either channel before giving up
   localparam int IDLE_LIMIT   = 2000;
   // hold-off after the last result (two-stage pipeline, plus slack)
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      int warning_dm;
      int danger_dm;
      int vehicle_dm;
      int margin_dm;
      bit auto_zoom;
      bit audio_alarm;
   } alarm_settings_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rtpa_req_if req_chan ();
   rtpa_rsp_if rsp_chan ();

   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [rtpa_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   radar_target_proximity_alarm_unit #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Predictor state: register copy plus the block's own target/buzzer state
   // -------------------------------------------------------------------------
   alarm_settings_type alarm_cfg = '{rtpa_pkg::WARNING_RST, rtpa_pkg::DANGER_RST,
                                     rtpa_pkg::VEH_W_RST, rtpa_pkg::MARGIN_RST,
                                     1'b1, 1'b1};
   bit         mdl_shown = 1'b0;
   bit         mdl_armed = 1'b0;
   bit         mdl_buzz  = 1'b0;
   int         mdl_ms    = 0;
   logic [1:0] mdl_beep  = rtpa_pkg::BEEP_400;

   rtpa_pkg::rtpa_rsp_type pending_updates [$];

   int mismatches      = 0;
   int results_checked = 0;
   int beats_sent      = 0;
   int frames_sent     = 0;
   int ticks_sent      = 0;
   int burst_left      = 0;
   int stall_mode      = 0;
   int stall_left      = 0;
   int idle_cycles     = 0;

   function automatic int floor_div(int n, int d);
      int q;
      q = n / d;
      if ((n % d != 0) && (n < 0))
         q = q - 1;
      return q;
   endfunction

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo)
         return lo;
      if (v > hi)
         return hi;
      return v;
   endfunction

   // disarmed silences, solid tone holds on, else 60 ms on / interval off
   function automatic void update_buzzer();
      int gap_ms;
      case (mdl_beep)
         rtpa_pkg::BEEP_80:  gap_ms = rtpa_pkg::INTERVAL_80;
         rtpa_pkg::BEEP_200: gap_ms = rtpa_pkg::INTERVAL_200;
         default:            gap_ms = rtpa_pkg::INTERVAL_400;
      endcase
      if (!mdl_armed) begin
         mdl_buzz = 1'b0;
      end else if (mdl_beep == rtpa_pkg::BEEP_SOLID) begin
         mdl_buzz = 1'b1;
      end else if (mdl_buzz) begin
         if (mdl_ms >= int'(rtpa_pkg::BEEP_ON_MS)) begin
            mdl_buzz = 1'b0;
            mdl_ms   = 0;
         end
      end else if (mdl_ms >= gap_ms) begin
         mdl_buzz = 1'b1;
         mdl_ms   = 0;
      end
   endfunction

   function automatic rtpa_pkg::rtpa_rsp_type predict_display_update(
         rtpa_pkg::rtpa_req_type rq);
      rtpa_pkg::rtpa_rsp_type upd;
      int  rng, fwd, lat, alat, g, tx, ty, vw, vx;
      bit  detection;
      upd = '0;
      upd.result_kind = rtpa_pkg::KIND_NONE;
      upd.zone        = rtpa_pkg::ZONE_SAFE;
      upd.grid_m      = rtpa_pkg::GRID_10;
      tx  = 0;
      ty  = 0;
      rng = rq.range_byte;
      fwd = rq.forward_byte;
      lat = int'(rq.lateral_byte) - 128;
      detection = (rq.req_type == rtpa_pkg::REQ_FRAME) && (rq.can_id >= rtpa_pkg::ID_LO) &&
                  (rq.can_id <= rtpa_pkg::ID_HI) && !rq.flag_byte[0];

      if (detection) begin
         if (alarm_cfg.auto_zoom) begin
            if (rng > int'(rtpa_pkg::BAND_SAFE_Q)) begin
               upd.zone = rtpa_pkg::ZONE_SAFE;    upd.grid_m = rtpa_pkg::GRID_10;
            end else if (rng > int'(rtpa_pkg::BAND_WARN_Q)) begin
               upd.zone = rtpa_pkg::ZONE_WARNING; upd.grid_m = rtpa_pkg::GRID_8;
            end else if (rng > int'(rtpa_pkg::BAND_DANGER_Q)) begin
               upd.zone = rtpa_pkg::ZONE_DANGER;  upd.grid_m = rtpa_pkg::GRID_6;
            end else begin
               upd.zone = rtpa_pkg::ZONE_ALARM;   upd.grid_m = rtpa_pkg::GRID_4;
            end
         end else begin
            // manual zoom: decimetre thresholds against quarter metres, no danger band
            if (5 * rng > 2 * alarm_cfg.warning_dm)
               upd.zone = rtpa_pkg::ZONE_SAFE;
            else if (5 * rng > 2 * alarm_cfg.danger_dm)
               upd.zone = rtpa_pkg::ZONE_WARNING;
            else
               upd.zone = rtpa_pkg::ZONE_ALARM;
         end
         g  = upd.grid_m;
         tx = floor_div(SCREEN_W * (lat + 2 * g) + 2 * g, 4 * g);
         tx = clamp_int(tx, 0, SCREEN_W - rtpa_pkg::BOX_PX);
         ty = floor_div(4 * g * SCREEN_H - fwd * SCREEN_W + 2 * g, 4 * g);
         ty = clamp_int(ty, 0, SCREEN_H - rtpa_pkg::BOX_PX);

         alat = (lat < 0) ? -lat : lat;
         if (alarm_cfg.audio_alarm && (5 * rng < 2 * alarm_cfg.warning_dm) &&
             (5 * alat < alarm_cfg.vehicle_dm + 2 * alarm_cfg.margin_dm)) begin
            mdl_armed = 1'b1;
            if (rng <= int'(rtpa_pkg::SOLID_Q))
               mdl_beep = rtpa_pkg::BEEP_SOLID;
            else if (upd.zone == rtpa_pkg::ZONE_ALARM)
               mdl_beep = rtpa_pkg::BEEP_80;
            else if (upd.zone == rtpa_pkg::ZONE_DANGER)
               mdl_beep = rtpa_pkg::BEEP_200;
            else
               mdl_beep = rtpa_pkg::BEEP_400;
         end else begin
            mdl_armed = 1'b0;
         end
         mdl_shown       = 1'b1;
         upd.result_kind = rtpa_pkg::KIND_SHOWN;
         upd.range_q     = rq.range_byte;
         upd.angle_deg   = rq.angle_byte ^ 8'h80;
         upd.forward_q   = rq.forward_byte;
         upd.lateral_q   = rq.lateral_byte ^ 8'h80;
         update_buzzer();
      end else if ((rq.req_type == rtpa_pkg::REQ_FRAME) ||
                   (rq.req_type == rtpa_pkg::REQ_TIMEOUT)) begin
         if (mdl_shown) begin
            mdl_shown       = 1'b0;
            mdl_armed       = 1'b0;
            upd.result_kind = rtpa_pkg::KIND_CLEARED;
         end
         update_buzzer();
      end else if (rq.req_type == rtpa_pkg::REQ_TICK) begin
         if (mdl_ms < int'(rtpa_pkg::CNT_MAX))
            mdl_ms++;
         update_buzzer();
      end

      g  = upd.grid_m;
      vw = floor_div(alarm_cfg.vehicle_dm * SCREEN_W + 5 * g, 10 * g);
      vw = clamp_int(vw, 2, SCREEN_W);
      vx = floor_div(SCREEN_W - vw + 1, 2);

      upd.target_x      = 8'(tx);
      upd.target_y      = 9'(ty);
      upd.vehicle_x     = 8'(vx);
      upd.vehicle_width = 9'(vw);
      upd.buzzer_level  = mdl_buzz;
      return upd;
   endfunction

   // -------------------------------------------------------------------------
   // Result side: stall pattern and field-by-field comparison
   // -------------------------------------------------------------------------
   function automatic void compare_field(string name, logic signed [31:0] want,
                                         logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_update(rtpa_pkg::rtpa_rsp_type got);
      rtpa_pkg::rtpa_rsp_type want;
      if (pending_updates.size() == 0) begin
         $error("result beat arrived with no prediction outstanding");
         mismatches++;
         return;
      end
      want = pending_updates.pop_front();
      results_checked++;
      compare_field("result_kind",   want.result_kind,   got.result_kind);
      compare_field("zone",          want.zone,          got.zone);
      compare_field("grid_m",        want.grid_m,        got.grid_m);
      compare_field("target_x",      want.target_x,      got.target_x);
      compare_field("target_y",      want.target_y,      got.target_y);
      compare_field("vehicle_x",     want.vehicle_x,     got.vehicle_x);
      compare_field("vehicle_width", want.vehicle_width, got.vehicle_width);
      compare_field("buzzer_level",  want.buzzer_level,  got.buzzer_level);
      compare_field("range_q",       want.range_q,       got.range_q);
      compare_field("angle_deg",     want.angle_deg,     got.angle_deg);
      compare_field("forward_q",     want.forward_q,     got.forward_q);
      compare_field("lateral_q",     want.lateral_q,     got.lateral_q);
   endtask

   // segments of: always ready, toggling, mostly ready, long stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            check_update(rsp_chan.payload);
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 60);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0:       rsp_chan.ready <= 1'b1;
            1:       rsp_chan.ready <= ~rsp_chan.ready;
            2:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_chan.ready <= ((stall_left % 12) < 3);
         endcase
      end
   end

   // watchdog: no beat on either side for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: %0d cycles without a beat, %0d predictions outstanding",
                  idle_cycles, pending_updates.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   function automatic rtpa_pkg::rtpa_req_type make_item(logic [1:0] req, int id, int rng,
                                                        int ang, int fwd, int lat,
                                                        int flag);
      rtpa_pkg::rtpa_req_type item;
      item.req_type     = req;
      item.can_id       = 11'(id);
      item.range_byte   = 8'(rng);
      item.angle_byte   = 8'(ang);
      item.forward_byte = 8'(fwd);
      item.lateral_byte = 8'(lat);
      item.flag_byte    = 8'(flag);
      return item;
   endfunction

   // payload bits are random even where the type says they are ignored
   function automatic rtpa_pkg::rtpa_req_type random_item_of(logic [1:0] req);
      return make_item(req, $urandom_range(0, 2047), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255));
   endfunction

   // close targets sit near the centre line, so they tend to arm the buzzer
   function automatic rtpa_pkg::rtpa_req_type random_detection(bit close);
      rtpa_pkg::rtpa_req_type item;
      item = random_item_of(rtpa_pkg::REQ_FRAME);
      item.can_id       = 11'($urandom_range(rtpa_pkg::ID_LO, rtpa_pkg::ID_HI));
      item.flag_byte[0] = 1'b0;
      if (close) begin
         item.range_byte   = 8'($urandom_range(0, 40));
         item.lateral_byte = 8'($urandom_range(122, 134));
      end
      return item;
   endfunction

   // frames that are mostly non-detections: flagged inside the id window, or fully random
   function automatic rtpa_pkg::rtpa_req_type random_noise_frame();
      rtpa_pkg::rtpa_req_type item;
      item = random_item_of(rtpa_pkg::REQ_FRAME);
      if ($urandom_range(0, 1)) begin
         item.can_id       = 11'($urandom_range(rtpa_pkg::ID_LO, rtpa_pkg::ID_HI));
         item.flag_byte[0] = 1'b1;
      end
      return item;
   endfunction

   // one request beat; bursts of random length separated by random gaps
   task automatic send_item(rtpa_pkg::rtpa_req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (!req_chan.ready);
      pending_updates.push_back(predict_display_update(item));
      burst_left--;
      beats_sent++;
      if (item.req_type == rtpa_pkg::REQ_FRAME)
         frames_sent++;
      if (item.req_type == rtpa_pkg::REQ_TICK)
         ticks_sent++;
   endtask

   // stop sending and wait for every predicted result to come back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_updates.size() != 0)
         @(posedge clock);
   endtask

   // all six registers, back-to-back APB writes (psel held through)
   task automatic apply_settings(alarm_settings_type s);
      logic [2:0] reg_idx [6];
      int         reg_val [6];
      reg_idx = '{rtpa_pkg::REG_WARNING, rtpa_pkg::REG_DANGER, rtpa_pkg::REG_VEH_W,
                  rtpa_pkg::REG_MARGIN, rtpa_pkg::REG_AUTOZOOM, rtpa_pkg::REG_AUDIO};
      reg_val = '{s.warning_dm, s.danger_dm, s.vehicle_dm, s.margin_dm,
                  int'(s.auto_zoom), int'(s.audio_alarm)};
      for (int i = 0; i < 6; i++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {reg_idx[i], 2'b00};
         csr_pwdata  <= 32'(reg_val[i]);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      alarm_cfg = s;
   endtask

   function automatic alarm_settings_type settings_of(int w, int d, int v, int m,
                                                     bit az, bit au);
      alarm_settings_type s;
      s = '{w, d, v, m, az, au};
      return s;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // reset register values; field extremes, id window edges, zoom band edges,
   // arming margin, solid tone, clearing and the ignored request type
   task automatic test_reset_directed();
      int band_edges [8] = '{21, 20, 13, 12, 7, 6, 4, 3};
      send_item(make_item(rtpa_pkg::REQ_TIMEOUT, 0, 0, 0, 0, 0, 0));   // nothing to clear
      send_item(make_item(rtpa_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0));
      send_item(make_item(REQ_UNUSED, 2047, 255, 255, 255, 255, 255));
      // clamps low x, high y
      send_item(make_item(rtpa_pkg::REQ_FRAME, rtpa_pkg::ID_LO, 0, 0, 0, 0, 0));
      send_item(make_item(rtpa_pkg::REQ_FRAME, rtpa_pkg::ID_HI, 255, 255, 255, 255, 8'hFE));
      // just below and just above the window
      send_item(make_item(rtpa_pkg::REQ_FRAME, rtpa_pkg::ID_LO - 1, 10, 128, 10, 128, 0));
      send_item(make_item(rtpa_pkg::REQ_FRAME, rtpa_pkg::ID_HI + 1, 10, 128, 10, 128, 0));
      foreach (band_edges[i])
         send_item(make_item(rtpa_pkg::REQ_FRAME, 11'h350, band_edges[i], 128,
                             band_edges[i], 128, 0));
      // last band edge is at the solid tone range: buzzer holds on
      send_item(make_item(rtpa_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0));
      send_item(make_item(rtpa_pkg::REQ_TICK, 2047, 255, 255, 255, 255, 255));
      // flagged invalid
      send_item(make_item(rtpa_pkg::REQ_FRAME, 11'h350, 10, 128, 10, 128, 8'h01));
      send_item(make_item(rtpa_pkg::REQ_FRAME, 2047, 10, 128, 10, 128, 0));
      send_item(make_item(rtpa_pkg::REQ_FRAME, 0, 10, 128, 10, 128, 0));
      // arms at 200 ms, then a timeout clears the target
      send_item(make_item(rtpa_pkg::REQ_FRAME, 11'h355, 10, 128, 40, 132, 0));
      send_item(make_item(rtpa_pkg::REQ_TIMEOUT, 0, 0, 0, 0, 0, 0));
      // lateral on margin
      send_item(make_item(rtpa_pkg::REQ_FRAME, 11'h355, 8, 128, 8, 134, 0));
      send_item(make_item(rtpa_pkg::REQ_FRAME, 11'h355, 8, 128, 8, 122, 0));
   endtask

   // idle for over 1023 ms while disarmed; an 80 ms target must then sound at
   // once, which a wrapping counter would get wrong
   task automatic test_tick_counter_saturation();
      send_item(random_item_of(rtpa_pkg::REQ_TIMEOUT));
      repeat (1040) send_item(random_item_of(rtpa_pkg::REQ_TICK));
      send_item(make_item(rtpa_pkg::REQ_FRAME, 11'h320, 5, 128, 5, 128, 0));
      repeat (150) send_item(random_item_of(rtpa_pkg::REQ_TICK));
   endtask

   // random traffic under one register setting; mostly well-formed detections
   // and armed targets followed by tick runs that cross the beep boundaries
   task automatic test_random_settings(alarm_settings_type s, int quota);
      int sent;
      int pick;
      int run;
      drain_results();
      apply_settings(s);
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_item(random_detection(1'b1));
            run = $urandom_range(0, 19);
            if (run < 15)
               run = $urandom_range(1, 40);
            else if (run < 19)
               run = $urandom_range(60, 220);
            else
               run = $urandom_range(400, 470);
            repeat (run) send_item(random_item_of(rtpa_pkg::REQ_TICK));
            sent += run + 1;
         end else if (pick < 55) begin
            send_item(random_detection(1'($urandom_range(0, 1))));
            sent++;
         end else if (pick < 65) begin
            send_item(random_item_of(rtpa_pkg::REQ_TIMEOUT));
            sent++;
         end else if (pick < 77) begin
            send_item(random_noise_frame());
            sent++;
         end else if (pick < 95) begin
            send_item(random_item_of(rtpa_pkg::REQ_TICK));
            sent++;
         end else begin
            send_item(random_item_of(REQ_UNUSED));   // ignored, not counted
         end
      end
   endtask

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_directed();
      test_tick_counter_saturation();
      test_random_settings(settings_of(rtpa_pkg::WARNING_RST, rtpa_pkg::DANGER_RST,
                                       rtpa_pkg::VEH_W_RST, rtpa_pkg::MARGIN_RST,
                                       1'b1, 1'b1), 100);
      test_random_settings(settings_of(0, 0, 0, 0, 1'b0, 1'b0), 70);
      test_random_settings(settings_of(255, 255, 255, 255, 1'b0, 1'b1), 80);
      test_random_settings(settings_of(60, 25, 18, 4, 1'b0, 1'b1), 80);
      test_random_settings(settings_of($urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 255),
                                       1'b1, 1'b1), 80);
      test_random_settings(settings_of($urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 255),
                                       1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1))), 70);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d request beats (%0d frames, %0d ticks) over six register settings,",
               beats_sent, frames_sent, ticks_sent);
      $display("including a saturated beep timer; %0d results compared, %0d mismatches.",
               results_checked, mismatches);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
